/* src/cthms_pkg.sv */
// Package for the countdown timer: request codes, register indexes, event bits,
// countdown constants and the structs passed between the timer modules.
// No dependencies.
package cthms_pkg;

    localparam int unsigned TimeWidth = 16;

    typedef enum logic [1:0] {
        REQ_TICK  = 2'd0,
        REQ_WRITE = 2'd1,
        REQ_READ  = 2'd2,
        REQ_NONE  = 2'd3
    } req_type_t;

    // Timer register indexes carried in reg_index
    localparam logic [2:0] IDX_HOURS    = 3'd0;
    localparam logic [2:0] IDX_MINUTES  = 3'd1;
    localparam logic [2:0] IDX_SECONDS  = 3'd2;
    localparam logic [2:0] IDX_SUBSEC   = 3'd3;
    localparam logic [2:0] IDX_RUN_FLAG = 3'd4;

    // Configuration register indexes (byte address = 4 * index)
    localparam logic CFG_EVENT_ENABLE    = 1'b0;
    localparam logic CFG_PRESCALE_RELOAD = 1'b1;

    // Bit positions in event_enable
    localparam int unsigned EV_FINAL  = 0;
    localparam int unsigned EV_TIMEUP = 1;
    localparam int unsigned EV_SECOND = 2;

    localparam logic [TimeWidth-1:0] BORROW_TOP      = 16'd59;
    localparam logic [TimeWidth-1:0] FINAL_SECONDS   = 16'd5;
    localparam logic [TimeWidth-1:0] PRESCALE_RESET  = 16'd3;

    typedef struct packed {
        logic [2:0]           event_enable;
        logic [TimeWidth-1:0] prescale_reload;
    } cthms_cfg_t;

    typedef struct packed {
        logic [TimeWidth-1:0] read_data;
        logic                 second_event;
        logic                 final_seconds_event;
        logic                 time_up_event;
        logic [1:0]           key_pushes;
        logic                 running;
    } cthms_result_t;

endpackage

/* src/cthms_apb.sv */
// APB-style configuration register file for the countdown timer.
// Depends on cthms_pkg for the register indexes and the configuration struct.
module cthms_apb (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [2:0]             paddr,
    input  logic [31:0]            pwdata,
    output logic [31:0]            prdata,
    output logic                   pready,
    output cthms_pkg::cthms_cfg_t  cfg
);
    import cthms_pkg::*;

    logic [2:0]           event_enable_reg;
    logic [TimeWidth-1:0] prescale_reload_reg;
    logic                 wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            event_enable_reg    <= 3'd0;
            prescale_reload_reg <= PRESCALE_RESET;
        end else if (wr_en) begin
            if (paddr[2] == CFG_EVENT_ENABLE) begin
                event_enable_reg <= pwdata[2:0];
            end else begin
                prescale_reload_reg <= pwdata[TimeWidth-1:0];
            end
        end
    end

    always_comb begin
        if (paddr[2] == CFG_PRESCALE_RELOAD) begin
            prdata = {16'd0, prescale_reload_reg};
        end else begin
            prdata = {29'd0, event_enable_reg};
        end
    end

    assign cfg.event_enable    = event_enable_reg;
    assign cfg.prescale_reload = prescale_reload_reg;

endmodule

/* src/cthms_core.sv */
// Timer state (hours, minutes, seconds, sub-second count, run flag) and the
// single-pass step logic for one request. Depends on cthms_pkg.
module cthms_core (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      fire,
    input  logic [1:0]                req_type,
    input  logic [2:0]                reg_index,
    input  logic [15:0]               write_value,
    input  cthms_pkg::cthms_cfg_t     cfg,
    output cthms_pkg::cthms_result_t  result
);
    import cthms_pkg::*;

    logic [TimeWidth-1:0] hours_reg, hours_next;
    logic [TimeWidth-1:0] minutes_reg, minutes_next;
    logic [TimeWidth-1:0] seconds_reg, seconds_next;
    logic [TimeWidth-1:0] subsec_reg, subsec_next;
    logic                 run_reg, run_next;
    logic                 ev_sec, ev_final, ev_up;
    logic [TimeWidth-1:0] rdata;

    always_comb begin
        hours_next   = hours_reg;
        minutes_next = minutes_reg;
        seconds_next = seconds_reg;
        subsec_next  = subsec_reg;
        run_next     = run_reg;
        ev_sec       = 1'b0;
        ev_final     = 1'b0;
        ev_up        = 1'b0;
        rdata        = '0;
        case (req_type_t'(req_type))
            REQ_TICK: begin
                if (run_reg) begin
                    if (subsec_reg != '0) begin
                        subsec_next = subsec_reg - 16'd1;
                    end else begin
                        ev_sec   = cfg.event_enable[EV_SECOND];
                        ev_final = cfg.event_enable[EV_FINAL] && (hours_reg == '0)
                                   && (minutes_reg == '0) && (seconds_reg <= FINAL_SECONDS);
                        subsec_next = cfg.prescale_reload;
                        if (seconds_reg != '0) begin
                            seconds_next = seconds_reg - 16'd1;
                        end else if (minutes_reg != '0) begin
                            seconds_next = BORROW_TOP;
                            minutes_next = minutes_reg - 16'd1;
                        end else if (hours_reg != '0) begin
                            seconds_next = BORROW_TOP;
                            minutes_next = BORROW_TOP;
                            hours_next   = hours_reg - 16'd1;
                        end else begin
                            // hours underflow: time is up, clear and stop
                            ev_up        = cfg.event_enable[EV_TIMEUP];
                            run_next     = 1'b0;
                            subsec_next  = '0;
                            seconds_next = '0;
                            minutes_next = '0;
                            hours_next   = '0;
                        end
                    end
                end
            end
            REQ_WRITE: begin
                case (reg_index)
                    IDX_HOURS:    hours_next   = write_value;
                    IDX_MINUTES:  minutes_next = write_value;
                    IDX_SECONDS:  seconds_next = write_value;
                    IDX_SUBSEC:   subsec_next  = write_value;
                    IDX_RUN_FLAG: run_next     = write_value[0];
                    default: ;
                endcase
            end
            REQ_READ: begin
                case (reg_index)
                    IDX_HOURS:    rdata = hours_reg;
                    IDX_MINUTES:  rdata = minutes_reg;
                    IDX_SECONDS:  rdata = seconds_reg;
                    IDX_SUBSEC:   rdata = subsec_reg;
                    IDX_RUN_FLAG: rdata = {15'd0, run_reg};
                    default:      rdata = '0;
                endcase
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hours_reg   <= '0;
            minutes_reg <= '0;
            seconds_reg <= '0;
            subsec_reg  <= '0;
            run_reg     <= 1'b0;
        end else if (fire) begin
            hours_reg   <= hours_next;
            minutes_reg <= minutes_next;
            seconds_reg <= seconds_next;
            subsec_reg  <= subsec_next;
            run_reg     <= run_next;
        end
    end

    assign result.read_data           = rdata;
    assign result.second_event        = ev_sec;
    assign result.final_seconds_event = ev_final;
    assign result.time_up_event       = ev_up;
    assign result.key_pushes          = {1'b0, ev_sec} + {1'b0, ev_final} + {1'b0, ev_up};
    assign result.running             = run_next;

    // time-up only comes from a zero time, which also meets the final-seconds test
    a_up_stops: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && ev_up |=> !run_reg && hours_reg == '0 && subsec_reg == '0)
        else $error("time-up did not clear and stop the timer");
    a_stopped_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        !run_reg |-> !ev_sec && !ev_final && !ev_up)
        else $error("event raised while the timer is stopped");
    a_idle_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        !fire |=> $stable(hours_reg) && $stable(subsec_reg) && $stable(run_reg))
        else $error("timer state moved without a request");

endmodule

/* src/countdown_timer_hms.sv */
// Top level of the countdown timer: input stage, result stage, configuration
// port. Depends on cthms_pkg, cthms_apb and cthms_core.
//
// Usage:
//   Requests enter on the s_ channel (s_valid/s_ready): a tick, a write of a
//   timer register or a read of one. Each request yields exactly one result on
//   the m_ channel (m_valid/m_ready) with read data, the fired events, the
//   count of key codes pushed and the run flag after the request.
//   Path: an accepted request waits in the input register, then its result is
//   shown on m_ (two register stages: input register, result register).
//   Throughput: one request per cycle unless m_ready stalls; the timer step is a
//   single short pass through the borrow chain between the two registers.
//   Stall: when m_ready is low the result holds; the input register still
//   takes one more request, then s_ready drops until the result is taken.
//   Reset (aresetn low, synchronous): both stages empty, time and run flag
//   cleared, event_enable = 0, prescale_reload = 3.
//   Configuration: APB-style, event_enable at 0x0, prescale_reload at 0x4;
//   write only while no request is in flight.
module countdown_timer_hms (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // request channel
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_req_type,
    input  logic [2:0]  s_reg_index,
    input  logic [15:0] s_write_value,
    // result channel
    output logic        m_valid,
    input  logic        m_ready,
    output logic [15:0] m_read_data,
    output logic        m_second_event,
    output logic        m_final_seconds_event,
    output logic        m_time_up_event,
    output logic [1:0]  m_key_pushes,
    output logic        m_running
);
    import cthms_pkg::*;

    cthms_cfg_t    cfg;
    cthms_result_t result;
    cthms_result_t res_reg;

    logic        in_valid_reg, in_valid_next;
    logic [1:0]  in_req_reg;
    logic [2:0]  in_idx_reg;
    logic [15:0] in_val_reg;
    logic        out_valid_reg, out_valid_next;
    logic        advance;
    logic        fire;

    cthms_apb u_apb (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // result slot is free when empty or being taken this cycle
    assign advance = !out_valid_reg || m_ready;
    assign fire    = in_valid_reg && advance;
    assign s_ready = !in_valid_reg || advance;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_ready) begin
            in_valid_next = s_valid;
        end
        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // capture the request payload
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_req_reg <= s_req_type;
            in_idx_reg <= s_reg_index;
            in_val_reg <= s_write_value;
        end
    end

    cthms_core u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .fire        (fire),
        .req_type    (in_req_reg),
        .reg_index   (in_idx_reg),
        .write_value (in_val_reg),
        .cfg         (cfg),
        .result      (result)
    );

    // load the result register as the timer step commits
    always_ff @(posedge aclk) begin
        if (fire) begin
            res_reg <= result;
        end
    end

    assign m_valid               = out_valid_reg;
    assign m_read_data           = res_reg.read_data;
    assign m_second_event        = res_reg.second_event;
    assign m_final_seconds_event = res_reg.final_seconds_event;
    assign m_time_up_event       = res_reg.time_up_event;
    assign m_key_pushes          = res_reg.key_pushes;
    assign m_running             = res_reg.running;

    a_hold_input: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !advance |=> in_valid_reg && $stable(in_req_reg))
        else $error("input stage dropped a stalled request");
    a_ready_low_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> in_valid_reg && out_valid_reg && !m_ready)
        else $error("s_ready low while a stage is free");
    a_fire_fills_out: assert property (@(posedge aclk) disable iff (!aresetn)
        fire |=> out_valid_reg)
        else $error("processed request did not reach the result stage");
    a_key_count: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> m_key_pushes == ({1'b0, m_second_event}
            + {1'b0, m_final_seconds_event} + {1'b0, m_time_up_event}))
        else $error("key push count does not match fired events");

endmodule

/* dv/countdown_timer_hms_test.sv */
// Self-checking testbench for countdown_timer_hms: random and directed requests
// are checked against a cycle-free countdown predictor kept inside this file.
// Depends on cthms_pkg and countdown_timer_hms.
module countdown_timer_hms_test;
    timeunit 1ns;
    timeprecision 1ps;

    import cthms_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int unsigned ERRORS_SHOWN = 10;
    // Timer register indexes that the block does not decode
    localparam logic [2:0] IDX_UNUSED_LO = 3'd5;
    localparam logic [2:0] IDX_UNUSED_HI = 3'd7;

    logic        aclk;
    logic        aresetn;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        s_valid;
    logic        s_ready;
    logic [1:0]  s_req_type;
    logic [2:0]  s_reg_index;
    logic [15:0] s_write_value;
    logic        m_valid;
    logic        m_ready;
    logic [15:0] m_read_data;
    logic        m_second_event;
    logic        m_final_seconds_event;
    logic        m_time_up_event;
    logic [1:0]  m_key_pushes;
    logic        m_running;

    countdown_timer_hms dut (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .psel                 (psel),
        .penable              (penable),
        .pwrite               (pwrite),
        .paddr                (paddr),
        .pwdata               (pwdata),
        .prdata               (prdata),
        .pready               (pready),
        .s_valid              (s_valid),
        .s_ready              (s_ready),
        .s_req_type           (s_req_type),
        .s_reg_index          (s_reg_index),
        .s_write_value        (s_write_value),
        .m_valid              (m_valid),
        .m_ready              (m_ready),
        .m_read_data          (m_read_data),
        .m_second_event       (m_second_event),
        .m_final_seconds_event(m_final_seconds_event),
        .m_time_up_event      (m_time_up_event),
        .m_key_pushes         (m_key_pushes),
        .m_running            (m_running)
    );

    // Predicted timer state and configuration, advanced once per accepted request
    logic [15:0] tmr_hours;
    logic [15:0] tmr_minutes;
    logic [15:0] tmr_seconds;
    logic [15:0] tmr_subsec;
    logic        tmr_run;
    logic [2:0]  cfg_enables;
    logic [15:0] cfg_reload;

    // Predicted results still waiting for the m_ channel, oldest first
    cthms_result_t pending_results[$];

    int unsigned sent_count;
    int unsigned checked_count;
    int unsigned error_count;
    int unsigned cycles_run;

    // Idling knobs for the two sides, and a long receiver hold-off on demand
    bit src_idling;
    bit sink_idling;
    int unsigned hold_off_request;

    // ------------------------------------------------------------------
    // Clock
    // ------------------------------------------------------------------
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // Predictor: apply one request to the timer state, return its result
    // ------------------------------------------------------------------
    function automatic cthms_result_t step_timer(req_type_t req, logic [2:0] idx,
                                                 logic [15:0] val);
        cthms_result_t r;
        logic sec_fire;
        logic final_fire;
        logic up_fire;
        r = '0;
        sec_fire = 1'b0;
        final_fire = 1'b0;
        up_fire = 1'b0;
        case (req)
            REQ_TICK: begin
                // A stopped timer ignores ticks
                if (tmr_run) begin
                    if (tmr_subsec != 16'd0) begin
                        tmr_subsec = tmr_subsec - 16'd1;
                    end else begin
                        // Second borrow: decide events on the time before counting down
                        sec_fire = cfg_enables[EV_SECOND];
                        final_fire = cfg_enables[EV_FINAL] && tmr_hours == 16'd0 &&
                                     tmr_minutes == 16'd0 && tmr_seconds <= FINAL_SECONDS;
                        tmr_subsec = cfg_reload;
                        if (tmr_seconds != 16'd0) begin
                            tmr_seconds = tmr_seconds - 16'd1;
                        end else begin
                            tmr_seconds = BORROW_TOP;
                            if (tmr_minutes != 16'd0) begin
                                tmr_minutes = tmr_minutes - 16'd1;
                            end else begin
                                tmr_minutes = BORROW_TOP;
                                if (tmr_hours != 16'd0) begin
                                    tmr_hours = tmr_hours - 16'd1;
                                end else begin
                                    // Hours underflow: time is up, clear and stop
                                    up_fire = cfg_enables[EV_TIMEUP];
                                    tmr_run = 1'b0;
                                    tmr_subsec = '0;
                                    tmr_seconds = '0;
                                    tmr_minutes = '0;
                                    tmr_hours = '0;
                                end
                            end
                        end
                    end
                end
            end
            REQ_WRITE: begin
                case (idx)
                    IDX_HOURS:    tmr_hours = val;
                    IDX_MINUTES:  tmr_minutes = val;
                    IDX_SECONDS:  tmr_seconds = val;
                    IDX_SUBSEC:   tmr_subsec = val;
                    IDX_RUN_FLAG: tmr_run = val[0];
                    default: ;
                endcase
            end
            REQ_READ: begin
                case (idx)
                    IDX_HOURS:    r.read_data = tmr_hours;
                    IDX_MINUTES:  r.read_data = tmr_minutes;
                    IDX_SECONDS:  r.read_data = tmr_seconds;
                    IDX_SUBSEC:   r.read_data = tmr_subsec;
                    IDX_RUN_FLAG: r.read_data = {15'd0, tmr_run};
                    default:      r.read_data = '0;
                endcase
            end
            default: ;
        endcase
        r.second_event = sec_fire;
        r.final_seconds_event = final_fire;
        r.time_up_event = up_fire;
        r.key_pushes = {1'b0, sec_fire} + {1'b0, final_fire} + {1'b0, up_fire};
        r.running = tmr_run;
        return r;
    endfunction

    function automatic string fmt_result(cthms_result_t r);
        return $sformatf("rd=%h sec=%b fin=%b up=%b keys=%0d run=%b", r.read_data,
                         r.second_event, r.final_seconds_event, r.time_up_event,
                         r.key_pushes, r.running);
    endfunction

    // Count every failure, show only the first few
    function automatic void log_failure(string what);
        error_count++;
        if (error_count <= ERRORS_SHOWN) begin
            $display("ERROR @%0t: %s", $realtime, what);
        end
    endfunction

    // ------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------

    // Offer one request and hold it until the block takes it. Valid stays
    // high afterwards so back-to-back requests need no idle gap; callers
    // drop it through drain_results or an idle burst.
    task automatic send_request(req_type_t req, logic [2:0] idx, logic [15:0] val);
        if (src_idling && $urandom_range(0, 4) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_req_type <= req;
        s_reg_index <= idx;
        s_write_value <= val;
        do @(posedge aclk); while (!s_ready);
        pending_results.push_back(step_timer(req, idx, val));
        sent_count++;
    endtask

    // Drop valid and wait until every predicted result has been checked, which
    // leaves both pipeline stages empty.
    task automatic drain_results();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending_results.size() != 0);
        repeat (4) @(posedge aclk);
    endtask

    // Write one configuration register with a setup phase and an access phase
    task automatic write_config(logic which, logic [31:0] value);
        drain_results();
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {which, 2'b00};
        pwdata <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (which == CFG_EVENT_ENABLE) begin
            cfg_enables = value[2:0];
        end else begin
            cfg_reload = value[15:0];
        end
    endtask

    // One unstructured request: mostly ticks, some reads and writes at any
    // index, now and then an undefined request type.
    task automatic send_random_request();
        int unsigned pick;
        logic [15:0] val;
        pick = $urandom_range(0, 19);
        val = ($urandom_range(0, 1) == 0) ? 16'($urandom) : 16'($urandom_range(0, 9));
        if (pick <= 10) begin
            send_request(REQ_TICK, 3'($urandom_range(0, 7)), 16'($urandom));
        end else if (pick <= 14) begin
            send_request(REQ_READ, 3'($urandom_range(0, 7)), 16'($urandom));
        end else if (pick <= 18) begin
            send_request(REQ_WRITE, 3'($urandom_range(0, 7)), val);
        end else begin
            send_request(REQ_NONE, 3'($urandom_range(0, 7)), 16'($urandom));
        end
    endtask

    // Load a short time, start the timer and tick it toward time-up with
    // reads mixed in; bail out after 120 ticks and reads in all.
    task automatic run_countdown();
        logic [15:0] run_val;
        int unsigned guard;
        run_val = 16'($urandom);
        run_val[0] = 1'b1;
        send_request(REQ_WRITE, IDX_HOURS,
                     ($urandom_range(0, 9) == 0) ? 16'd1 : 16'd0);
        send_request(REQ_WRITE, IDX_MINUTES,
                     ($urandom_range(0, 4) == 0) ? 16'd1 : 16'd0);
        send_request(REQ_WRITE, IDX_SECONDS, 16'($urandom_range(0, 8)));
        send_request(REQ_WRITE, IDX_SUBSEC, 16'($urandom_range(0, 3)));
        send_request(REQ_WRITE, IDX_RUN_FLAG, run_val);
        guard = 0;
        while (tmr_run && guard < 120) begin
            if ($urandom_range(0, 5) == 0) begin
                send_request(REQ_READ, 3'($urandom_range(0, 4)), 16'($urandom));
            end else begin
                send_request(REQ_TICK, 3'($urandom_range(0, 7)), 16'($urandom));
            end
            guard++;
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reads after reset, a tick while stopped, unknown indexes and request type
    task automatic test_reset_and_ignored();
        send_request(REQ_READ, IDX_HOURS, 16'd0);
        send_request(REQ_READ, IDX_MINUTES, 16'd0);
        send_request(REQ_READ, IDX_SECONDS, 16'd0);
        send_request(REQ_READ, IDX_SUBSEC, 16'd0);
        send_request(REQ_READ, IDX_RUN_FLAG, 16'd0);
        send_request(REQ_TICK, IDX_HOURS, 16'hFFFF);
        send_request(REQ_NONE, IDX_SUBSEC, 16'hFFFF);
        send_request(REQ_WRITE, IDX_UNUSED_HI, 16'hFFFF);
        send_request(REQ_READ, IDX_UNUSED_LO, 16'd0);
        send_request(REQ_READ, IDX_UNUSED_HI, 16'd0);
    endtask

    // All events on, no prescale: second and final-seconds events, then all three events at once
    task automatic test_time_up();
        write_config(CFG_EVENT_ENABLE, 32'd7);
        write_config(CFG_PRESCALE_RELOAD, 32'd0);
        send_request(REQ_WRITE, IDX_SECONDS, 16'd1);
        send_request(REQ_WRITE, IDX_RUN_FLAG, 16'd1);
        send_request(REQ_TICK, IDX_HOURS, 16'd0);
        send_request(REQ_TICK, IDX_HOURS, 16'd0);
        send_request(REQ_READ, IDX_RUN_FLAG, 16'd0);
    endtask

    // Borrow through minutes into hours
    task automatic test_hour_borrow();
        send_request(REQ_WRITE, IDX_HOURS, 16'd1);
        send_request(REQ_WRITE, IDX_RUN_FLAG, 16'd1);
        send_request(REQ_TICK, IDX_HOURS, 16'd0);
        send_request(REQ_READ, IDX_HOURS, 16'd0);
        send_request(REQ_READ, IDX_MINUTES, 16'd0);
    endtask

    // Full-scale register values; a tick only decrements the prescaler
    task automatic test_full_scale();
        send_request(REQ_WRITE, IDX_HOURS, 16'hFFFF);
        send_request(REQ_WRITE, IDX_MINUTES, 16'hFFFF);
        send_request(REQ_WRITE, IDX_SUBSEC, 16'hFFFF);
        send_request(REQ_TICK, IDX_HOURS, 16'd0);
        send_request(REQ_READ, IDX_SUBSEC, 16'd0);
    endtask

    // Hold the receiver off long enough to fill both stages and stall s_ready,
    // keep offering requests meanwhile, then let everything drain
    task automatic test_result_backpressure();
        src_idling = 1'b0;
        sink_idling = 1'b0;
        hold_off_request = 300;
        repeat (40) send_random_request();
        drain_results();
        repeat (20) send_random_request();
    endtask

    // Random traffic under a sweep of configurations; the last phase runs
    // with no idling on either side
    task automatic test_random_sweep();
        logic [2:0]  enable_plan [6];
        logic [31:0] reload_plan [6];
        int unsigned phase_end;
        enable_plan = '{3'd7, 3'd0, 3'd5, 3'd2, 3'($urandom_range(0, 7)), 3'd4};
        reload_plan = '{32'd0, 32'h0000FFFF, 32'd1, 32'd2,
                        32'($urandom_range(0, 3)), 32'd3};
        for (int p = 0; p < 6; p++) begin
            write_config(CFG_EVENT_ENABLE, {29'd0, enable_plan[p]});
            write_config(CFG_PRESCALE_RELOAD, reload_plan[p]);
            src_idling = (p != 5);
            sink_idling = (p != 5);
            phase_end = sent_count + 50;
            while (sent_count < phase_end) begin
                if ($urandom_range(0, 3) == 0) begin
                    run_countdown();
                end else begin
                    send_random_request();
                end
            end
        end
        // Mid-range prescaler with its upper byte set
        write_config(CFG_PRESCALE_RELOAD, 32'h0000A5A5);
        repeat (10) send_random_request();
    endtask

    // ------------------------------------------------------------------
    // Receiver: random stall bursts, plus a long hold-off when requested
    // ------------------------------------------------------------------
    initial begin : drive_result_ready
        int unsigned stall_left;
        int unsigned hold_left;
        stall_left = 0;
        hold_left = 0;
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_off_request != 0) begin
                hold_left = hold_off_request;
                hold_off_request = 0;
            end
            if (hold_left != 0) begin
                m_ready <= 1'b0;
                hold_left--;
            end else if (stall_left != 0) begin
                m_ready <= 1'b0;
                stall_left--;
            end else if (sink_idling && $urandom_range(0, 5) == 0) begin
                // this cycle counts as the first of the burst
                m_ready <= 1'b0;
                stall_left = $urandom_range(0, 7);
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result checker: compare every accepted result with the oldest prediction
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : check_results
        cthms_result_t got;
        cthms_result_t want;
        if (aresetn && m_valid && m_ready) begin
            got.read_data = m_read_data;
            got.second_event = m_second_event;
            got.final_seconds_event = m_final_seconds_event;
            got.time_up_event = m_time_up_event;
            got.key_pushes = m_key_pushes;
            got.running = m_running;
            if (pending_results.size() == 0) begin
                log_failure($sformatf("result with no request outstanding: %s",
                                      fmt_result(got)));
            end else begin
                want = pending_results.pop_front();
                if (got !== want) begin
                    log_failure($sformatf("result %0d: expected %s, actual %s",
                                          checked_count, fmt_result(want),
                                          fmt_result(got)));
                end
                checked_count++;
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: end a hung run
    // ------------------------------------------------------------------
    initial begin : watchdog
        cycles_run = 0;
        while (cycles_run < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycles_run++;
        end
        $display("status: fail");
        $finish;
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        // Hold every input at a known value from time zero
        aresetn <= 1'b0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        s_valid <= 1'b0;
        s_req_type <= REQ_TICK;
        s_reg_index <= IDX_HOURS;
        s_write_value <= '0;

        // Predictor starts from the reset state
        tmr_hours = '0;
        tmr_minutes = '0;
        tmr_seconds = '0;
        tmr_subsec = '0;
        tmr_run = 1'b0;
        cfg_enables = '0;
        cfg_reload = PRESCALE_RESET;
        sent_count = 0;
        checked_count = 0;
        error_count = 0;
        hold_off_request = 0;
        src_idling = 1'b1;
        sink_idling = 1'b1;

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        test_reset_and_ignored();
        test_time_up();
        test_hour_borrow();
        test_full_scale();
        test_result_backpressure();
        test_random_sweep();

        // Let the pipeline empty and the bench settle
        drain_results();
        repeat (8) @(posedge aclk);

        if (error_count == 0 && pending_results.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
